/* src/bbq_pkg.sv */
// shared types, constants and codes for the byte budget tail drop queue
package bbq_pkg;

    localparam int FIFO_DEPTH = 64;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam int LEN_W      = 16;
    localparam int BYTES_W    = 20;
    localparam int RATE_W     = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;

    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 136;

    localparam logic [BYTES_W-1:0] MAX_BYTES_RESET = 20'd65536;
    localparam logic [RATE_W-1:0]  RATE_RESET      = 16'd1;

    typedef enum logic [1:0] {
        EV_ACCEPTED = 2'd0,
        EV_DROPPED  = 2'd1,
        EV_DEPARTED = 2'd2
    } event_t;

    typedef enum logic {
        KIND_ARRIVAL = 1'b0,
        KIND_TICK    = 1'b1
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_QUEUE_BYTES      = 1'b0,
        CFG_DRAIN_BYTES_PER_TICK = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [31:0]      stamp;
        logic [31:0]      seq;
        logic [15:0]      dst;
        logic [15:0]      src;
    } descriptor_t;

    typedef struct packed {
        logic        is_tick;
        descriptor_t desc;
    } command_t;

endpackage

/* src/bbq_front.sv */
// front end: takes input transfers, classifies them and queues commands
module bbq_front
    import bbq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    input  logic                 s_axis_tuser,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output command_t             cmd
);

    command_t   entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;
    command_t   in_cmd;

    always_comb begin
        in_cmd.is_tick    = (s_axis_tuser == KIND_TICK);
        in_cmd.desc.src   = s_axis_tdata[15:0];
        in_cmd.desc.dst   = s_axis_tdata[31:16];
        in_cmd.desc.seq   = s_axis_tdata[63:32];
        in_cmd.desc.stamp = s_axis_tdata[95:64];
        in_cmd.desc.len   = s_axis_tdata[111:96];
    end

    assign s_axis_tready = (count_reg != 2'd2);
    assign cmd_valid     = (count_reg != 2'd0);
    assign cmd           = entry_reg[rd_ptr_reg];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("front queue count out of range");
    a_full_no_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd2 && !pop) |=> count_reg == 2'd2)
        else $error("front queue lost an entry while full");
    a_ptrs_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("front queue pointers disagree while empty");
`endif

endmodule

/* src/bbq_back.sv */
// back end: descriptor memory, byte budget, drain countdown and result register
module bbq_back
    import bbq_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  command_t              cmd,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic [1:0]            m_axis_tuser
);

    typedef enum logic {
        ST_RUN,
        ST_LOAD
    } state_t;

    descriptor_t mem [FIFO_DEPTH];
    descriptor_t rd_data_reg;

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [BYTES_W-1:0] qbytes_reg, qbytes_next;
    logic               serializing_reg, serializing_next;
    logic [LEN_W-1:0]   remain_reg, remain_next;
    descriptor_t        head_reg, head_next;
    logic [BYTES_W-1:0] max_bytes_reg;
    logic [RATE_W-1:0]  rate_reg;

    logic               out_valid_reg, out_valid_next;
    event_t             out_event_reg, out_event_next;
    descriptor_t        out_desc_reg, out_desc_next;
    logic [BYTES_W-1:0] out_qbytes_reg, out_qbytes_next;

    logic               go;
    logic               wr_en, rd_en;
    logic [BYTES_W:0]   sum_bytes;
    logic               accept;
    logic               depart;
    logic [PTR_W-1:0]   rd_ptr_inc, wr_ptr_inc;

    assign cfg_ready = 1'b1;
    assign go        = cmd_valid && (state_reg == ST_RUN) && (!out_valid_reg || m_axis_tready);
    assign cmd_ready = go;

    assign sum_bytes = {1'b0, qbytes_reg} + {{(BYTES_W + 1 - LEN_W){1'b0}}, cmd.desc.len};
    assign accept    = (count_reg != CNT_W'(FIFO_DEPTH)) && (sum_bytes <= {1'b0, max_bytes_reg});
    assign depart    = serializing_reg && (remain_reg <= rate_reg);

    assign rd_ptr_inc = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
    assign wr_ptr_inc = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;

    always_comb begin
        state_next       = state_reg;
        wr_ptr_next      = wr_ptr_reg;
        rd_ptr_next      = rd_ptr_reg;
        count_next       = count_reg;
        qbytes_next      = qbytes_reg;
        serializing_next = serializing_reg;
        remain_next      = remain_reg;
        head_next        = head_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_event_next   = out_event_reg;
        out_desc_next    = out_desc_reg;
        out_qbytes_next  = out_qbytes_reg;
        wr_en            = 1'b0;
        rd_en            = 1'b0;

        unique case (state_reg)
            ST_RUN: begin
                if (go) begin
                    if (!cmd.is_tick) begin
                        out_valid_next = 1'b1;
                        out_desc_next  = cmd.desc;
                        if (accept) begin
                            wr_en           = 1'b1;
                            wr_ptr_next     = wr_ptr_inc;
                            count_next      = count_reg + 1'b1;
                            qbytes_next     = sum_bytes[BYTES_W-1:0];
                            out_event_next  = EV_ACCEPTED;
                            out_qbytes_next = sum_bytes[BYTES_W-1:0];
                            if (!serializing_reg) begin
                                serializing_next = 1'b1;
                                head_next        = cmd.desc;
                                remain_next      = cmd.desc.len;
                            end
                        end else begin
                            out_event_next  = EV_DROPPED;
                            out_qbytes_next = qbytes_reg;
                        end
                    end else if (depart) begin
                        out_valid_next   = 1'b1;
                        out_event_next   = EV_DEPARTED;
                        out_desc_next    = head_reg;
                        rd_ptr_next      = rd_ptr_inc;
                        count_next       = count_reg - 1'b1;
                        qbytes_next      = (qbytes_reg >= BYTES_W'(head_reg.len))
                                           ? qbytes_reg - BYTES_W'(head_reg.len) : '0;
                        out_qbytes_next  = qbytes_next;
                        serializing_next = 1'b0;
                        remain_next      = '0;
                        if (count_reg != CNT_W'(1)) begin
                            rd_en      = 1'b1;
                            state_next = ST_LOAD;
                        end
                    end else if (serializing_reg) begin
                        remain_next = remain_reg - rate_reg;
                    end
                end
            end
            ST_LOAD: begin
                head_next        = rd_data_reg;
                remain_next      = rd_data_reg.len;
                serializing_next = 1'b1;
                state_next       = ST_RUN;
            end
            default: state_next = ST_RUN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_RUN;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
            qbytes_reg      <= '0;
            serializing_reg <= 1'b0;
            remain_reg      <= '0;
            out_valid_reg   <= 1'b0;
            max_bytes_reg   <= MAX_BYTES_RESET;
            rate_reg        <= RATE_RESET;
        end else begin
            state_reg       <= state_next;
            wr_ptr_reg      <= wr_ptr_next;
            rd_ptr_reg      <= rd_ptr_next;
            count_reg       <= count_next;
            qbytes_reg      <= qbytes_next;
            serializing_reg <= serializing_next;
            remain_reg      <= remain_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_MAX_QUEUE_BYTES:      max_bytes_reg <= cfg_data[BYTES_W-1:0];
                    CFG_DRAIN_BYTES_PER_TICK: rate_reg      <= cfg_data[RATE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        head_reg       <= head_next;
        out_event_reg  <= out_event_next;
        out_desc_reg   <= out_desc_next;
        out_qbytes_reg <= out_qbytes_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= cmd.desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_ptr_inc];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_event_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - IN_DATA_W - BYTES_W){1'b0}}, out_qbytes_reg,
                            out_desc_reg.len, out_desc_reg.stamp, out_desc_reg.seq,
                            out_desc_reg.dst, out_desc_reg.src};

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("entry count beyond depth");
    a_serializing_has_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        serializing_reg |-> (count_reg != '0))
        else $error("serializing with an empty queue");
    a_empty_no_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (qbytes_reg == '0))
        else $error("bytes left over in an empty queue");
    a_load_after_depart: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD) |-> (!serializing_reg && count_reg != '0))
        else $error("head load without a waiting entry");
`endif

endmodule

/* src/byte_budget_tail_drop_queue_top.sv */
// path: each input transfer is registered in the front queue, and its result then in the output register
// throughput: 1 item per cycle while the output is not stalled; a departure that brings up a new
// head stalls the input for the registered read of the descriptor memory
// reset: synchronous active-low aresetn empties the queue and restores the
// byte budget to 65536 and the drain rate to 1 byte per tick
module byte_budget_tail_drop_queue_top
    import bbq_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // source_id, destination_id, sequence_number, time_stamp, length_bytes
    input  logic                  s_axis_tuser,  // kind
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // out_source, out_destination, out_sequence, out_stamp, out_length, queued_bytes_now, zero pad
    output logic [1:0]            m_axis_tuser,  // event_res
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic     cmd_valid;
    logic     cmd_ready;
    command_t cmd;

    bbq_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd)
    );

    bbq_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
